// ===== sv/scoped_symbol_stack_assert.svh =====
// Assertion macros for the scoped symbol stack checker.
// Depends on nothing; included by sss_checker.sv.
`ifndef SCOPED_SYMBOL_STACK_ASSERT_SVH
`define SCOPED_SYMBOL_STACK_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset.
`define SSS_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block clock and reset.
`define SSS_ASSERT(label, prop, msg) \
  `SSS_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/sss_pkg.sv =====
// Package for the scoped symbol stack: sizes, codes, entry and result types.
// Used by the top level, sss_seq, sss_match and sss_checker; depends on nothing.
`timescale 1ns / 1ps

package sss_pkg;

  localparam int unsigned ENTRIES   = 256;
  localparam int unsigned KEY_BITS  = 64;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DEPTH_W   = 8;
  localparam int unsigned SIZE_W    = 8;
  localparam int unsigned IDX_OUT_W = 8;
  localparam int unsigned CNT_OUT_W = 9;

  localparam logic [CNT_W-1:0]     FULL_COUNT     = CNT_W'(ENTRIES);
  localparam logic [CNT_OUT_W-1:0] FULL_COUNT_OUT = CNT_OUT_W'(ENTRIES);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_FIND      = 3'd2,
    OP_GET_SIZE  = 3'd3,
    OP_SET_INIT  = 3'd4,
    OP_READ_INIT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [DEPTH_W-1:0]  depth;
    logic [SIZE_W-1:0]   size;
    logic                init;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_BITS-1:0] key;
    logic [DEPTH_W-1:0]  depth;
    logic [SIZE_W-1:0]   size;
  } cmd_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic [SIZE_W-1:0]    size_out;
    logic                 init_flag;
    status_e              status;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  function automatic logic [IDX_OUT_W-1:0] idx_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+IDX_OUT_W-1:0] wide;
    wide = {{IDX_OUT_W{1'b0}}, idx};
    return wide[IDX_OUT_W-1:0];
  endfunction

  function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+CNT_OUT_W-1:0] wide;
    wide = {{CNT_OUT_W{1'b0}}, cnt};
    return wide[CNT_OUT_W-1:0];
  endfunction

endpackage

// ===== sv/scoped_symbol_stack.sv =====
// Top level of the scoped symbol stack: stream ports, entry RAM, output register.
// Depends on sss_pkg, sss_ram and sss_seq.
//
// A stack of symbol entries (key, scope depth, size, initialized mark).
// Input beats on s_axis carry one operation each: push, pop, find index,
// get size, set initialized or read initialized, selected by tuser.
// Every input beat gives exactly one output beat on m_axis with the entry
// index, size, mark, status and the entry count after the operation.
// The block works on one operation at a time; s_axis_tready is high only
// while the sequencer is idle.
// Push and pop go through S_EXEC (a pop with entries also S_POP_RD) and
// S_DONE; a lookup reads the entry RAM one entry per cycle from index 0
// upward through its one read port, until it hits or reaches the entry count.
// Reset empties the stack at once; the entry RAM is never cleared.
// A stalled m_axis holds its beat in the output register; the sequencer
// finishes the next operation and waits with its result until that beat
// is taken.
`timescale 1ns / 1ps

module scoped_symbol_stack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [63:0] name_key, [71:64] scope_depth, [79:72] size_value
  input  logic [79:0] s_axis_tdata,
  // [2:0] op
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] entry_index, [15:8] size_out, [16] init_flag, [25:17] entry_count
  output logic [31:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import sss_pkg::*;

  cmd_t             cmd;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  ram_wr_t          ram_wr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             out_valid_q;
  res_t             out_q;

  assign cmd.op    = s_axis_tuser;
  assign cmd.key   = s_axis_tdata[KEY_BITS-1:0];
  assign cmd.depth = s_axis_tdata[71:64];
  assign cmd.size  = s_axis_tdata[79:72];

  sss_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  sss_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.entry_count, out_q.init_flag, out_q.size_out,
                          out_q.entry_index};
  assign m_axis_tuser  = out_q.status;

endmodule

// ===== sv/sss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the symbol entries of the stack.
`timescale 1ns / 1ps

module sss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/sss_match.sv =====
// Compare unit of the lookup scan: tests one stored entry against the searched key and depth.
// Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_match (
  input  sss_pkg::entry_t                      entry_i,
  input  logic [sss_pkg::KEY_BITS-1:0]         key_i,
  input  logic [sss_pkg::DEPTH_W-1:0]          depth_i,
  output logic                                 match_o
);
  import sss_pkg::*;

  assign match_o = (entry_i.depth == depth_i) && (entry_i.key == key_i);

endmodule

// ===== sv/sss_seq.sv =====
// Sequencer of the symbol stack: push, pop and the upward lookup scan.
// Depends on sss_pkg and sss_match; drives the entry RAM in the top level.
`timescale 1ns / 1ps

module sss_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sss_pkg::cmd_t             in_cmd_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output sss_pkg::res_t             res_o,
  output sss_pkg::ram_wr_t          ram_wr_o,
  output logic [sss_pkg::IDX_W-1:0] ram_raddr_o,
  input  sss_pkg::entry_t           ram_rdata_i
);
  import sss_pkg::*;

  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  res_t             res_q, res_d;

  logic             match;
  logic             hit;
  logic             scan_end;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] cnt_inc;

  sss_match u_match (
    .entry_i (ram_rdata_i),
    .key_i   (cmd_q.key),
    .depth_i (cmd_q.depth),
    .match_o (match)
  );

  assign hit      = pend_q && match;
  assign scan_end = (ptr_q >= count_q);
  assign cnt_dec  = count_q - 1'b1;
  assign cnt_inc  = count_q + 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q.op)
          OP_POP: begin
            state_d = (count_q == '0) ? S_DONE : S_POP_RD;
          end
          OP_FIND, OP_GET_SIZE, OP_SET_INIT, OP_READ_INIT: begin
            state_d = S_SCAN;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_POP_RD: begin
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_wr_o    = '0;
    ram_raddr_o = ptr_q[IDX_W-1:0];
    cmd_d       = cmd_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = in_cmd_i;
          ptr_d = '0;
        end
      end
      S_EXEC: begin
        res_d             = '0;
        res_d.status      = ST_OK;
        res_d.entry_count = cnt_out(count_q);
        case (cmd_q.op)
          OP_PUSH: begin
            if (count_q == FULL_COUNT) begin
              res_d.status = ST_FULL;
            end else begin
              ram_wr_o.we         = 1'b1;
              ram_wr_o.addr       = count_q[IDX_W-1:0];
              ram_wr_o.data.key   = cmd_q.key;
              ram_wr_o.data.depth = cmd_q.depth;
              ram_wr_o.data.size  = cmd_q.size;
              ram_wr_o.data.init  = 1'b0;
              count_d             = cnt_inc;
              res_d.entry_index   = idx_out(count_q[IDX_W-1:0]);
              res_d.size_out      = cmd_q.size;
              res_d.entry_count   = cnt_out(cnt_inc);
            end
          end
          OP_POP: begin
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
            end else begin
              ram_raddr_o = cnt_dec[IDX_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      S_POP_RD: begin
        count_d           = cnt_dec;
        res_d.entry_index = idx_out(cnt_dec[IDX_W-1:0]);
        res_d.size_out    = ram_rdata_i.size;
        res_d.init_flag   = ram_rdata_i.init;
        res_d.entry_count = cnt_out(cnt_dec);
      end
      S_SCAN: begin
        if (hit) begin
          res_d.entry_index = idx_out(cmp_idx_q);
          res_d.size_out    = ram_rdata_i.size;
          res_d.init_flag   = ram_rdata_i.init;
          if (cmd_q.op == OP_SET_INIT) begin
            ram_wr_o.we        = 1'b1;
            ram_wr_o.addr      = cmp_idx_q;
            ram_wr_o.data      = ram_rdata_i;
            ram_wr_o.data.init = 1'b1;
            res_d.init_flag    = 1'b1;
          end
        end else if (scan_end) begin
          res_d.status = ST_NOT_FOUND;
        end else begin
          pend_d    = 1'b1;
          cmp_idx_d = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + 1'b1;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    ptr_q     <= ptr_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
  end

endmodule

// ===== sv/sss_checker.sv =====
// Port-level checker for the scoped symbol stack, bound to the top level.
// Depends on sss_pkg and scoped_symbol_stack_assert.svh.
`timescale 1ns / 1ps
`include "scoped_symbol_stack_assert.svh"

module sss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import sss_pkg::*;

  logic                 in_beat;
  logic                 out_stall;
  logic [33:0]          out_beat;
  logic [CNT_OUT_W-1:0] out_count;
  logic                 out_is_full;
  logic                 out_is_empty;

  assign in_beat      = s_axis_tvalid && s_axis_tready;
  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign out_beat     = {m_axis_tuser, m_axis_tdata};
  assign out_count    = m_axis_tdata[25:17];
  assign out_is_full  = m_axis_tvalid && (m_axis_tuser == ST_FULL);
  assign out_is_empty = m_axis_tvalid && (m_axis_tuser == ST_EMPTY);

  `SSS_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_beat), "stalled beat changed")
  `SSS_ASSERT(a_busy_after_accept, in_beat |=> !s_axis_tready, "input taken while busy")
  `SSS_ASSERT(a_count_range, m_axis_tvalid |-> out_count <= FULL_COUNT_OUT, "count above capacity")
  `SSS_ASSERT(a_full_count, out_is_full |-> out_count == FULL_COUNT_OUT, "full status, not full")
  `SSS_ASSERT(a_empty_count, out_is_empty |-> out_count == '0, "empty status with entries")

endmodule

bind scoped_symbol_stack sss_checker u_sss_checker (.*);
